// ===== hdl/rlpe_pkg.sv =====
// Shared constants for the recursive length-prefix encoder.
`timescale 1ns / 1ps
`default_nettype none

package rlpe_pkg;

    // Width of one emitted code byte
    localparam int BYTE_W = 8;

    // Widest header: "10 0 11 0", L1 in 3 bits, 0, L0 in up to 7 bits, 0
    localparam int HDR_W = 18;

    // Width of the header length count (at most 18)
    localparam int HDR_LEN_W = 5;

    // Leading fields shared by all codes with L0 >= 3: length 2, 0, length 3, 0
    localparam int                 PREFIX_W = 6;
    localparam logic [PREFIX_W-1:0] PREFIX  = 6'b100110;

    // Header lengths of each form, separators included; the long form adds L1
    localparam logic [HDR_LEN_W-1:0] HDR_LEN_TINY  = 5'd3;
    localparam logic [HDR_LEN_W-1:0] HDR_LEN_THREE = 5'd6;
    localparam logic [HDR_LEN_W-1:0] HDR_LEN_MID   = 5'd10;
    localparam logic [HDR_LEN_W-1:0] HDR_LEN_LONG  = 5'd11;

endpackage : rlpe_pkg

`default_nettype wire

// ===== hdl/recursive_length_prefix_encoder_core.sv =====
// Recursive length-prefix encoder: one value in, its code out as a byte stream.
//
// Usage
//   Input channel: value with value_valid / value_stall. A transaction is
//   taken when value_valid is high and value_stall is low.
//   Output channel: code_byte and last_byte with code_valid / code_stall.
//   Each value yields 1 to 11 bytes, first code bit in the MSB, the last byte
//   zero padded and flagged by last_byte.
// Timing
//   A value is captured into an input register, encoded combinationally and
//   loaded into the byte shift register, whose top byte is shown on code_byte
//   straight away. The shift register sends one byte per cycle while
//   code_stall is low; a code has (code bits + 7) / 8 bytes, 1 to 11. The next
//   value is encoded into the shift register in the same cycle that the last
//   byte of the previous one is taken, so bytes stream without gaps. One
//   further value waits in the input register.
// Reset and stall
//   rst_n clears both valid flags and the byte count; nothing is sent until a
//   value arrives. While code_stall is high the shown byte holds, and once the
//   input register is full and cannot pass its value on, value_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module recursive_length_prefix_encoder_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic [63:0] value,
    input  wire logic        value_valid,
    output logic             value_stall,

    output logic [7:0]       code_byte,
    output logic             last_byte,
    output logic             code_valid,
    input  wire logic        code_stall
);

    // Longest code is the fixed overhead of 19 bits plus the value bits
    localparam int CODE_BITS = rlpe_pkg::BYTE_W
                               * ((VALUE_WIDTH + 19 + rlpe_pkg::BYTE_W - 1) / rlpe_pkg::BYTE_W);
    localparam int CODE_BYTES = CODE_BITS / rlpe_pkg::BYTE_W;
    localparam int CNT_W      = $clog2(CODE_BYTES + 1);
    localparam int LW         = $clog2(VALUE_WIDTH + 1);
    localparam int NW         = $clog2(CODE_BITS + 1);

    // Input register
    logic                   in_valid_reg;
    logic [VALUE_WIDTH-1:0] in_value_reg;

    // Byte shift register and count of bytes still to send
    logic [CODE_BITS-1:0]   code_reg;
    logic [CNT_W-1:0]       count_reg;

    logic                   out_take;
    logic                   buf_free;
    logic                   load;

    logic [LW-1:0]          l0;
    logic [2:0]             l1;
    logic [rlpe_pkg::HDR_W-1:0]     hdr;
    logic [rlpe_pkg::HDR_LEN_W-1:0] hdr_len;
    logic [NW-1:0]          total_len;
    logic [NW:0]            total_round;
    logic [CODE_BITS-1:0]   tail;
    logic [CODE_BITS-1:0]   raw;
    logic [CODE_BITS-1:0]   code_next;
    logic [CNT_W-1:0]       count_next;

    // Handshake
    assign code_valid  = (count_reg != '0);
    assign out_take    = code_valid && !code_stall;
    assign buf_free    = (count_reg == '0) || ((count_reg == CNT_W'(1)) && out_take);
    assign load        = in_valid_reg && buf_free;
    assign value_stall = in_valid_reg && !load;

    assign code_byte = code_reg[CODE_BITS-1 -: rlpe_pkg::BYTE_W];
    assign last_byte = (count_reg == CNT_W'(1));

    // Bit length of the value
    always_comb
    begin
        l0 = '0;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (in_value_reg[i])
            begin
                l0 = LW'(i + 1);
            end
        end
    end

    // Bit length of the value's length (at most 7)
    always_comb
    begin
        l1 = '0;
        for (int i = 0; i < LW; i++)
        begin
            if (l0[i])
            begin
                l1 = 3'(i + 1);
            end
        end
    end

    // Length fields in front of the value, each followed by a 0 bit
    always_comb
    begin
        priority if (l0 <= LW'(2))
        begin
            hdr     = rlpe_pkg::HDR_W'({l0[1:0], 1'b0});
            hdr_len = rlpe_pkg::HDR_LEN_TINY;
        end
        else if (l0 == LW'(3))
        begin
            hdr     = rlpe_pkg::HDR_W'(rlpe_pkg::PREFIX);
            hdr_len = rlpe_pkg::HDR_LEN_THREE;
        end
        else if (l0 <= LW'(7))
        begin
            hdr     = rlpe_pkg::HDR_W'({rlpe_pkg::PREFIX, l0[2:0], 1'b0});
            hdr_len = rlpe_pkg::HDR_LEN_MID;
        end
        else
        begin
            hdr     = (rlpe_pkg::HDR_W'({rlpe_pkg::PREFIX, l1, 1'b0}) << ({1'b0, l1} + 4'd1))
                      | rlpe_pkg::HDR_W'({l0, 1'b0});
            hdr_len = rlpe_pkg::HDR_LEN_LONG + rlpe_pkg::HDR_LEN_W'(l1);
        end
    end

    // Assemble header, value bits and the closing 1, then left-justify
    always_comb
    begin
        tail        = CODE_BITS'({in_value_reg, 1'b1});
        raw         = (CODE_BITS'(hdr) << ({1'b0, l0} + (LW + 1)'(1))) | tail;
        total_len   = NW'(hdr_len) + NW'(l0) + NW'(1);
        code_next   = raw << (NW'(CODE_BITS) - total_len);
        total_round = {1'b0, total_len} + (NW + 1)'(rlpe_pkg::BYTE_W - 1);
        count_next  = CNT_W'(total_round >> 3);
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!value_stall)
        begin
            in_valid_reg <= value_valid;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (value_valid && !value_stall)
        begin
            in_value_reg <= value[VALUE_WIDTH-1:0];
        end
    end

    // Byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= count_next;
        end
        else if (out_take)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Code bits, shifted one byte per transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= code_next;
        end
        else if (out_take)
        begin
            code_reg <= code_reg << rlpe_pkg::BYTE_W;
        end
    end

endmodule : recursive_length_prefix_encoder_core

`default_nettype wire
